@@ design/lebs_pkg.sv @@
`timescale 1ns / 1ps

package lebs_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned PatternLen = 6;

  // led bit positions in a lit mask
  localparam logic [2:0] LedNone = 3'b000;
  localparam logic [2:0] LedG = 3'b001;
  localparam logic [2:0] LedY = 3'b010;
  localparam logic [2:0] LedR = 3'b100;
  localparam logic [2:0] LedAll = 3'b111;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgMaxBrightness = 2'd0,
    CfgFlashInterval = 2'd1,
    CfgPause         = 2'd2,
    CfgBufferCode    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  max_brightness;
    logic [15:0] flash_interval_ms;
    logic [15:0] pause_ms;
    logic [3:0]  buffer_error_code;
  } cfg_t;

  localparam logic [7:0]  RstMaxBrightness = 8'd255;
  localparam logic [15:0] RstFlashInterval = 16'd500;
  localparam logic [15:0] RstPause = 16'd3000;
  localparam logic [3:0]  RstBufferCode = 4'd7;

  // pattern index 0..5 (code 1..6), position 0..7; past the table is a terminator
  function automatic logic [2:0] pattern_entry(input logic [2:0] pat, input logic [2:0] pos);
    logic [2:0] e;
    e = LedNone;
    unique case (pat)
      3'd0: begin
        if (pos == 3'd0 || pos == 3'd2) e = LedR;
      end
      3'd1: begin
        if (pos == 3'd0) e = LedY;
        else if (pos == 3'd1) e = LedR;
      end
      3'd2: begin
        if (pos == 3'd0 || pos == 3'd2) e = LedR;
        else if (pos == 3'd1) e = LedY;
      end
      3'd3: begin
        if (pos == 3'd0) e = LedG;
        else if (pos == 3'd1) e = LedY;
      end
      3'd4: begin
        if (pos <= 3'd2) e = LedR;
      end
      3'd5: begin
        if (pos == 3'd0 || pos == 3'd2) e = LedY;
        else if (pos == 3'd1) e = LedG;
      end
      default: e = LedNone;
    endcase
    return e;
  endfunction

endpackage

@@ design/lebs_cfg.sv @@
`timescale 1ns / 1ps

module lebs_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  lebs_pkg::cfg_reg_e                   cfg_index_i,
  input  logic [lebs_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output lebs_pkg::cfg_t                       cfg_o
);
  import lebs_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_brightness    <= RstMaxBrightness;
      cfg_q.flash_interval_ms <= RstFlashInterval;
      cfg_q.pause_ms          <= RstPause;
      cfg_q.buffer_error_code <= RstBufferCode;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMaxBrightness: cfg_q.max_brightness    <= cfg_data_i[7:0];
        CfgFlashInterval: cfg_q.flash_interval_ms <= cfg_data_i;
        CfgPause:         cfg_q.pause_ms          <= cfg_data_i;
        CfgBufferCode:    cfg_q.buffer_error_code <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/lebs_step.sv @@
`timescale 1ns / 1ps

module lebs_step #(
  parameter int unsigned TIME_WIDTH = lebs_pkg::TimeWidth
) (
  input  lebs_pkg::cfg_t        cfg_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  input  logic [3:0]            code_i,
  input  logic [TIME_WIDTH-1:0] last_step_i,
  input  logic [TIME_WIDTH-1:0] pause_begin_i,
  input  logic [2:0]            pos_i,
  input  logic                  pausing_i,
  input  logic [2:0]            lit_i,
  output logic [TIME_WIDTH-1:0] last_step_o,
  output logic [TIME_WIDTH-1:0] pause_begin_o,
  output logic [2:0]            pos_o,
  output logic                  pausing_o,
  output logic [2:0]            lit_o
);
  import lebs_pkg::*;

  logic [TIME_WIDTH-1:0] since_step, since_pause, interval, pause_len;
  logic [2:0] pat, entry;

  assign since_step  = now_i - last_step_i;
  assign since_pause = now_i - pause_begin_i;
  assign interval    = TIME_WIDTH'(cfg_i.flash_interval_ms);
  assign pause_len   = TIME_WIDTH'(cfg_i.pause_ms);
  // out-of-range codes fall back to the first pattern
  assign pat   = (code_i >= 4'd1 && code_i <= 4'd6) ? 3'(code_i - 4'd1) : 3'd0;
  assign entry = pattern_entry(pat, pos_i);

  always_comb begin
    last_step_o   = last_step_i;
    pause_begin_o = pause_begin_i;
    pos_o         = pos_i;
    pausing_o     = pausing_i;
    lit_o         = lit_i;
    priority if (code_i == cfg_i.buffer_error_code) begin
      lit_o = LedAll;
    end else if (pausing_i) begin
      lit_o = LedNone;
      if (since_pause >= pause_len) begin
        pausing_o = 1'b0;
        pos_o     = 3'd0;
      end
    end else if (since_step >= interval) begin
      last_step_o = now_i;
      if (entry == LedNone) begin
        lit_o         = LedNone;
        pausing_o     = 1'b1;
        pause_begin_o = now_i;
        pos_o         = 3'd0;
      end else begin
        lit_o = entry;
        pos_o = pos_i + 3'd1;
      end
    end
  end

endmodule

@@ design/led_error_blink_sequencer_top.sv @@
`timescale 1ns / 1ps

// led error blink sequencer
// input channel: one word per tick with now_ms_i (millisecond timestamp) and
// error_code_i, valid/stall handshake; accepted when in_valid_i and !in_stall_o
// output channel: one word per input word with green/yellow/red levels,
// each either 0 or max_brightness; taken when out_valid_o and !out_stall_i
// config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high, write only while no word is in flight
// path: an accepted word is registered in the input register, and its result
// is registered in the result register when the word advances to it
// throughput: one word per cycle while the result register is not stalled,
// set by the combinational blink state update between the two registers
// stall: when the result register is full and stalled, a word in the input
// register holds and in_stall_o goes high; no word is lost or repeated
// reset: control, config and blink state registers return to defaults, leds off, pattern at its start
module led_error_blink_sequencer_top #(
  parameter int unsigned TIME_WIDTH = lebs_pkg::TimeWidth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [TIME_WIDTH-1:0]                now_ms_i,
  input  logic [3:0]                           error_code_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [7:0]                           green_level_o,
  output logic [7:0]                           yellow_level_o,
  output logic [7:0]                           red_level_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  lebs_pkg::cfg_reg_e                   cfg_index_i,
  input  logic [lebs_pkg::CfgDataWidth-1:0]    cfg_data_i
);
  import lebs_pkg::*;

  cfg_t cfg;

  logic                  in_valid_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic [3:0]            code_q;

  logic [TIME_WIDTH-1:0] last_step_q, last_step_d, pause_begin_q, pause_begin_d;
  logic [2:0]            pos_q, pos_d, lit_q, lit_d;
  logic                  pausing_q, pausing_d;

  logic       out_valid_q;
  logic [7:0] green_q, yellow_q, red_q;
  logic       advance, accept;

  lebs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lebs_step #(.TIME_WIDTH(TIME_WIDTH)) u_step (
    .cfg_i        (cfg),
    .now_i        (now_q),
    .code_i       (code_q),
    .last_step_i  (last_step_q),
    .pause_begin_i(pause_begin_q),
    .pos_i        (pos_q),
    .pausing_i    (pausing_q),
    .lit_i        (lit_q),
    .last_step_o  (last_step_d),
    .pause_begin_o(pause_begin_d),
    .pos_o        (pos_d),
    .pausing_o    (pausing_d),
    .lit_o        (lit_d)
  );

  // the registered word moves on when the result register is free or drains
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q  <= now_ms_i;
      code_q <= error_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_step_q   <= '0;
      pause_begin_q <= '0;
      pos_q         <= 3'd0;
      pausing_q     <= 1'b0;
      lit_q         <= LedNone;
    end else if (advance) begin
      last_step_q   <= last_step_d;
      pause_begin_q <= pause_begin_d;
      pos_q         <= pos_d;
      pausing_q     <= pausing_d;
      lit_q         <= lit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      green_q  <= lit_d[0] ? cfg.max_brightness : 8'd0;
      yellow_q <= lit_d[1] ? cfg.max_brightness : 8'd0;
      red_q    <= lit_d[2] ? cfg.max_brightness : 8'd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign green_level_o  = green_q;
  assign yellow_level_o = yellow_q;
  assign red_level_o    = red_q;

endmodule

@@ test/led_error_blink_sequencer_top_tb.sv @@
`timescale 1ns / 1ps

module led_error_blink_sequencer_top_tb;
  import lebs_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int PhaseWords = 188;
  localparam int OpeningCount = 24;

  typedef struct packed {
    logic [7:0] green;
    logic [7:0] yellow;
    logic [7:0] red;
  } leds_t;

  // one row of the opening sequence; typed rows carry their own expected levels
  typedef struct packed {
    logic [31:0] now;
    logic [3:0]  code;
    logic        typed;
    leds_t       want;
  } probe_word_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [31:0]             now_ms_i = '0;
  logic [3:0]              error_code_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [7:0]              green_level_o;
  logic [7:0]              yellow_level_o;
  logic [7:0]              red_level_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  cfg_reg_e                cfg_index_i = CfgMaxBrightness;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;

  // predicted blink state and register copies
  logic [7:0]  bright = RstMaxBrightness;
  logic [15:0] flash_gap = RstFlashInterval;
  logic [15:0] pause_len = RstPause;
  logic [3:0]  buf_code = RstBufferCode;
  logic [31:0] step_time = '0;
  logic [31:0] pause_start = '0;
  logic [2:0]  step_pos = '0;
  logic        in_pause = 1'b0;
  logic [2:0]  lit = LedNone;

  leds_t pending_leds[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int buffer_words = 0;
  int pauses_begun = 0;
  int settings_run = 1;
  int quiet_cycles = 0;
  logic [31:0] clock_ms = '0;
  logic [3:0]  cur_code = 4'd1;

  probe_word_t opening_words [OpeningCount] = '{
    {32'd0,          4'd1,  1'b1, 8'd0,   8'd0,   8'd0},
    {32'd499,        4'd9,  1'b0, 24'd0},
    {32'd500,        4'd1,  1'b1, 8'd0,   8'd0,   8'd255},
    {32'd700,        4'd7,  1'b1, 8'd255, 8'd255, 8'd255},
    {32'd800,        4'd1,  1'b1, 8'd255, 8'd255, 8'd255},
    {32'd1000,       4'd1,  1'b1, 8'd0,   8'd0,   8'd0},
    {32'd3999,       4'd2,  1'b0, 24'd0},
    {32'd4000,       4'd2,  1'b0, 24'd0},
    {32'd4000,       4'd2,  1'b0, 24'd0},
    {32'd4500,       4'd3,  1'b0, 24'd0},
    {32'd5000,       4'd5,  1'b0, 24'd0},
    {32'd5500,       4'd5,  1'b0, 24'd0},
    {32'd8500,       4'd7,  1'b1, 8'd255, 8'd255, 8'd255},
    {32'd8500,       4'd4,  1'b0, 24'd0},
    {32'd9000,       4'd4,  1'b0, 24'd0},
    {32'd9500,       4'd6,  1'b0, 24'd0},
    {32'd10000,      4'd0,  1'b0, 24'd0},
    {32'd10500,      4'd15, 1'b0, 24'd0},
    {32'd13500,      4'd10, 1'b0, 24'd0},
    {32'hFFFF_FE00,  4'd8,  1'b0, 24'd0},
    {32'h0000_0100,  4'd11, 1'b0, 24'd0},
    {32'hFFFF_FFFF,  4'd12, 1'b0, 24'd0},
    {32'hFFFF_FFFF,  4'd13, 1'b0, 24'd0},
    {32'hFFFF_FFFF,  4'd7,  1'b1, 8'd255, 8'd255, 8'd255}
  };

  led_error_blink_sequencer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .now_ms_i      (now_ms_i),
    .error_code_i  (error_code_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .green_level_o (green_level_o),
    .yellow_level_o(yellow_level_o),
    .red_level_o   (red_level_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // led lit by a pattern entry; positions past the pattern are terminators
  function automatic logic [2:0] flash_led(input logic [2:0] pat, input logic [2:0] pos);
    logic [17:0] row;
    case (pat)
      3'd1: row = {LedNone, LedNone, LedNone, LedNone, LedR, LedY};
      3'd2: row = {LedNone, LedNone, LedNone, LedR, LedY, LedR};
      3'd3: row = {LedNone, LedNone, LedNone, LedNone, LedY, LedG};
      3'd4: row = {LedNone, LedNone, LedNone, LedR, LedR, LedR};
      3'd5: row = {LedNone, LedNone, LedNone, LedY, LedG, LedY};
      default: row = {LedNone, LedNone, LedNone, LedR, LedNone, LedR};
    endcase
    if (pos >= PatternLen) return LedNone;
    return row[int'(pos) * 3 +: 3];
  endfunction

  task automatic advance_blink(input logic [31:0] now, input logic [3:0] code,
                               output leds_t lv);
    logic [2:0]  pat;
    logic [2:0]  entry;
    logic [31:0] elapsed;
    if (code == buf_code) begin
      lit = LedAll;
      buffer_words++;
    end else begin
      pat = (code >= 4'd1 && code <= 4'd6) ? 3'(code - 4'd1) : 3'd0;
      if (in_pause) begin
        elapsed = now - pause_start;
        if (elapsed >= 32'(pause_len)) begin
          in_pause = 1'b0;
          step_pos = '0;
        end
        lit = LedNone;
      end else begin
        elapsed = now - step_time;
        if (elapsed >= 32'(flash_gap)) begin
          step_time = now;
          entry = flash_led(pat, step_pos);
          if (entry == LedNone) begin
            lit = LedNone;
            in_pause = 1'b1;
            pause_start = now;
            step_pos = '0;
            pauses_begun++;
          end else begin
            lit = entry;
            step_pos = step_pos + 3'd1;
          end
        end
      end
    end
    lv.green = lit[0] ? bright : 8'd0;
    lv.yellow = lit[1] ? bright : 8'd0;
    lv.red = lit[2] ? bright : 8'd0;
  endtask

  task automatic send_word(input logic [31:0] now, input logic [3:0] code,
                           input logic typed, input leds_t want);
    leds_t lv;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    now_ms_i <= now;
    error_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
    advance_blink(now, code, lv);
    pending_leds.push_back(typed ? want : lv);
    words_sent++;
  endtask

  task automatic drain_results;
    in_valid_i <= 1'b0;
    while (pending_leds.size() != 0) @(posedge clk_i);
  endtask

  // writes all four registers back to back; block must be idle
  task automatic load_settings(input logic [7:0] b, input logic [15:0] gap,
                               input logic [15:0] pz, input logic [3:0] bc);
    cfg_reg_e idx;
    logic [15:0] data;
    for (int k = 0; k < 4; k++) begin
      idx = cfg_reg_e'(k);
      case (idx)
        CfgMaxBrightness: data = {8'd0, b};
        CfgFlashInterval: data = gap;
        CfgPause:         data = pz;
        default:          data = {12'd0, bc};
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i <= data;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    bright = b;
    flash_gap = gap;
    pause_len = pz;
    buf_code = bc;
    settings_run++;
  endtask

  task automatic run_phase(input int count);
    int r;
    int c;
    logic [3:0] code;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 45) clock_ms += $urandom_range(0, 2 * int'(flash_gap));
      else if (r < 55) clock_ms += 32'(flash_gap) - $urandom_range(0, 1);
      else if (r < 65) clock_ms += 32'(pause_len) - $urandom_range(0, 1);
      else if (r < 80) clock_ms += $urandom_range(0, 2 * int'(pause_len));
      else if (r < 88) clock_ms += 0;
      else if (r < 94) clock_ms = $urandom();
      else clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * int'(pause_len));
      c = $urandom_range(99);
      if (c < 8) cur_code = 4'($urandom_range(15));
      code = (c >= 8 && c < 13) ? buf_code : cur_code;
      send_word(clock_ms, code, 1'b0, '0);
      // the last word is drained below
      if ($urandom_range(199) == 0 && i < count - 1) drain_results();
    end
    drain_results();
  endtask

  task automatic compare_level(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    leds_t want;
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_leds.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none actual g %0d y %0d r %0d",
                   $time, green_level_o, yellow_level_o, red_level_o);
        end else begin
          want = pending_leds.pop_front();
          compare_level("green_level", want.green, green_level_o);
          compare_level("yellow_level", want.yellow, yellow_level_o);
          compare_level("red_level", want.red, red_level_o);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d words outstanding",
                 $time, QuietLimit, pending_leds.size());
        $display("led_error_blink_sequencer_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    send_idle_pct = 38;
    recv_stall_pct = 81;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: first flash, buffer code hold, pause, code change, wrap
    foreach (opening_words[i]) begin
      send_word(opening_words[i].now, opening_words[i].code, opening_words[i].typed,
                opening_words[i].want);
    end
    drain_results();
    clock_ms = 32'd20000;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0, 1: begin
          send_idle_pct = 38;
          recv_stall_pct = 81;
        end
        2, 3: begin
          send_idle_pct = 81;
          recv_stall_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      case (ph)
        1: load_settings(8'd0, 16'd1, 16'd1, 4'd0);
        2: load_settings(8'd255, 16'd65535, 16'd65535, 4'd15);
        3: load_settings(8'd128, 16'd50, 16'd300, 4'd3);
        4: load_settings(8'($urandom_range(255)), 16'($urandom_range(1, 65535)),
                         16'($urandom_range(1, 65535)), 4'($urandom_range(15)));
        5: load_settings(8'($urandom_range(255)), 16'($urandom_range(1, 20)),
                         16'($urandom_range(1, 60)), 4'($urandom_range(15)));
        default: ;
      endcase
      run_phase(PhaseWords);
    end

    while (pending_leds.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("%0d words over %0d register settings, %0d results checked",
             words_sent, settings_run, results_seen);
    $display("%0d buffer-code words, %0d pauses entered, %0d mismatches",
             buffer_words, pauses_begun, errors);
    if (errors == 0) begin
      $display("led_error_blink_sequencer_top: match");
    end else begin
      $display("led_error_blink_sequencer_top: mismatch");
    end
    $finish;
  end

endmodule
